FILE: hdl/vas_pkg.sv
// Package for the vibration alert sequencer: item, state and config types, codes.
`default_nettype none
package vas_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SETUP  = 3'd1,
        PH_ON     = 3'd2,
        PH_OFF    = 3'd3,
        PH_REPEAT = 3'd4,
        PH_GAP    = 3'd5
    } vas_phase_t;

    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_PHONE_NEW  = 3'd1;
    localparam logic [2:0] CMD_PHONE_DEL  = 3'd2;
    localparam logic [2:0] CMD_PHONE_STOP = 3'd3;
    localparam logic [2:0] CMD_IDLE_ALERT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CALL_REM     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OTHER_REM    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_REM     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CALL_CAT     = 3'd7;

    localparam logic [15:0] ON_TIME_RST   = 16'd100;
    localparam logic [15:0] OFF_TIME_RST  = 16'd400;
    localparam logic [3:0]  PULSES_RST    = 4'd3;
    localparam logic [15:0] GAP_TIME_RST  = 16'd2000;
    localparam logic [4:0]  CALL_REM_RST  = 5'd15;
    localparam logic [4:0]  OTHER_REM_RST = 5'd1;
    localparam logic [4:0]  IDLE_REM_RST  = 5'd3;
    localparam logic [7:0]  CALL_CAT_RST  = 8'd1;

    localparam logic [3:0] PULSE_MAX = 4'd15;
    localparam logic [4:0] BURST_MAX = 5'd31;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  category;
        logic [31:0] now_ms;
    } vas_in_t;

    typedef struct packed {
        logic       vibrator_on;
        logic       busy_res;
        logic       display_wake;
        logic [2:0] phase;
    } vas_out_t;

    typedef struct packed {
        logic [15:0] on_time_ms;
        logic [15:0] off_time_ms;
        logic [3:0]  pulses_per_burst;
        logic [15:0] reminder_gap_ms;
        logic [4:0]  call_reminders;
        logic [4:0]  other_reminders;
        logic [4:0]  idle_alert_reminders;
        logic [7:0]  call_category;
    } vas_cfg_t;

    typedef struct packed {
        vas_phase_t  phase;
        logic [31:0] mark_time;
        logic [3:0]  pulse_count;
        logic [4:0]  burst_count;
        logic [4:0]  burst_limit;
        logic        motor_level;
    } vas_state_t;

endpackage
`default_nettype wire

FILE: hdl/vas_step.sv
// Next-state and result logic for one command or tick item.
`default_nettype none
module vas_step (
    input  wire vas_pkg::vas_state_t cur,
    input  wire vas_pkg::vas_cfg_t   cfg,
    input  wire vas_pkg::vas_in_t    item,
    output vas_pkg::vas_state_t nxt,
    output vas_pkg::vas_out_t   res
);
    import vas_pkg::*;

    logic [15:0] dur;
    logic [31:0] limit_time;
    logic        expired;
    logic        wake;

    always_comb
    begin
        unique case (cur.phase)
            PH_OFF:    dur = cfg.on_time_ms;
            PH_REPEAT: dur = cfg.off_time_ms;
            default:   dur = cfg.reminder_gap_ms;
        endcase
    end

    assign limit_time = cur.mark_time + {16'd0, dur};
    assign expired    = item.now_ms > limit_time;

    always_comb
    begin
        nxt  = cur;
        wake = 1'b0;
        unique case (item.cmd)
            CMD_TICK:
            begin
                unique case (cur.phase)
                    PH_SETUP:
                    begin
                        nxt.phase       = PH_ON;
                        nxt.burst_count = 5'd0;
                    end
                    PH_ON:
                    begin
                        nxt.mark_time   = item.now_ms;
                        nxt.motor_level = 1'b1;
                        nxt.phase       = PH_OFF;
                    end
                    PH_OFF:
                    begin
                        if (expired)
                        begin
                            nxt.motor_level = 1'b0;
                            nxt.phase       = PH_REPEAT;
                            nxt.mark_time   = item.now_ms;
                            if (cur.pulse_count < PULSE_MAX)
                            begin
                                nxt.pulse_count = cur.pulse_count + 4'd1;
                            end
                        end
                    end
                    PH_REPEAT:
                    begin
                        if (expired)
                        begin
                            if (cur.pulse_count >= cfg.pulses_per_burst)
                            begin
                                nxt.phase     = PH_GAP;
                                nxt.mark_time = item.now_ms;
                                if (cur.burst_count < BURST_MAX)
                                begin
                                    nxt.burst_count = cur.burst_count + 5'd1;
                                end
                            end
                            else
                            begin
                                nxt.phase = PH_ON;
                            end
                        end
                    end
                    PH_GAP:
                    begin
                        if (expired)
                        begin
                            if (cur.burst_count >= cur.burst_limit)
                            begin
                                nxt.phase = PH_IDLE;
                            end
                            else
                            begin
                                nxt.phase       = PH_ON;
                                nxt.pulse_count = 4'd0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_PHONE_NEW:
            begin
                nxt.pulse_count = 4'd0;
                nxt.burst_count = 5'd0;
                nxt.burst_limit = (item.category == cfg.call_category) ?
                                  cfg.call_reminders : cfg.other_reminders;
                nxt.phase       = PH_SETUP;
                wake            = 1'b1;
            end
            CMD_PHONE_DEL, CMD_PHONE_STOP:
            begin
                nxt.phase       = PH_IDLE;
                nxt.motor_level = 1'b0;
            end
            CMD_IDLE_ALERT:
            begin
                nxt.pulse_count = 4'd0;
                nxt.burst_count = 5'd0;
                nxt.burst_limit = cfg.idle_alert_reminders;
                nxt.phase       = PH_SETUP;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res.vibrator_on  = nxt.motor_level;
        res.busy_res     = (nxt.phase != PH_IDLE);
        res.display_wake = wake;
        res.phase        = nxt.phase;
    end

endmodule
`default_nettype wire

FILE: hdl/vibration_alert_sequencer.sv
// Top level of the vibration alert sequencer: config registers, state and result register.
//
//  channel | signals                          | dir | accepted when
//  --------+----------------------------------+-----+----------------------
//  in      | in_valid, in_ready, in_data      | in  | in_valid & in_ready
//  out     | out_valid, out_ready, out_data   | out | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_data      | in  | cfg_we
//
// One item per cycle while in_ready is high; its result sits in the output register from the cycle after acceptance.
// The state update and result come from a single add and compare against the mark time.
// in_ready drops only while a result waits in the output register and out_ready is low.
// rst_n clears the sequencer state, the output valid and loads config reset values.
`default_nettype none
module vibration_alert_sequencer (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  vas_pkg::vas_in_t             in_data,
    output logic                               out_valid,
    input  wire                                out_ready,
    output vas_pkg::vas_out_t                  out_data,
    input  wire                                cfg_we,
    input  wire  [vas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [vas_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vas_pkg::*;

    vas_cfg_t   cfg_reg;
    vas_state_t state_reg;
    vas_state_t state_next;
    vas_out_t   res_next;
    vas_out_t   out_data_reg;
    logic       out_valid_reg;
    logic       in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_time_ms           <= ON_TIME_RST;
            cfg_reg.off_time_ms          <= OFF_TIME_RST;
            cfg_reg.pulses_per_burst     <= PULSES_RST;
            cfg_reg.reminder_gap_ms      <= GAP_TIME_RST;
            cfg_reg.call_reminders       <= CALL_REM_RST;
            cfg_reg.other_reminders      <= OTHER_REM_RST;
            cfg_reg.idle_alert_reminders <= IDLE_REM_RST;
            cfg_reg.call_category        <= CALL_CAT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ON_TIME:   cfg_reg.on_time_ms           <= cfg_data;
                CFG_OFF_TIME:  cfg_reg.off_time_ms          <= cfg_data;
                CFG_PULSES:    cfg_reg.pulses_per_burst     <= cfg_data[3:0];
                CFG_GAP_TIME:  cfg_reg.reminder_gap_ms      <= cfg_data;
                CFG_CALL_REM:  cfg_reg.call_reminders       <= cfg_data[4:0];
                CFG_OTHER_REM: cfg_reg.other_reminders      <= cfg_data[4:0];
                CFG_IDLE_REM:  cfg_reg.idle_alert_reminders <= cfg_data[4:0];
                CFG_CALL_CAT:  cfg_reg.call_category        <= cfg_data[7:0];
            endcase
        end
    end

    vas_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (in_data),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_IDLE;
            state_reg.mark_time   <= 32'd0;
            state_reg.pulse_count <= 4'd0;
            state_reg.burst_count <= 5'd0;
            state_reg.burst_limit <= 5'd0;
            state_reg.motor_level <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_busy_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.busy_res == (out_data.phase != PH_IDLE)))
        else $error("busy_res disagrees with phase");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.cmd == CMD_PHONE_DEL || in_data.cmd == CMD_PHONE_STOP))
        |=> (state_reg.phase == PH_IDLE && !state_reg.motor_level && !out_data.vibrator_on))
        else $error("delete or stop did not end the sequence");

    a_new_wakes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.cmd == CMD_PHONE_NEW)
        |=> (out_valid && out_data.display_wake && state_reg.phase == PH_SETUP))
        else $error("phone new did not raise display wake");

    a_wake_only_new: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.cmd != CMD_PHONE_NEW) |=> !out_data.display_wake)
        else $error("display wake without phone new");

endmodule
`default_nettype wire
